@@ src/positional_array_list_macros.svh @@
// Assertion macros for the positional array list
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH
`ifndef SYNTHESIS
`define PAL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion %m failed");
`define PAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion %m failed");
`else
`define PAL_ASSERT(lbl, clk, rst_n, prop)
`define PAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/pal_pkg.sv @@
`timescale 1ns / 1ps
package pal_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 8;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_LOCATE,
    OP_GET
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_BAD_POSITION,
    ST_NOT_FOUND
  } status_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_sel_t;

  typedef enum logic [1:0] {
    ADR_IDX,
    ADR_IDX_M1,
    ADR_POS_M1
  } adr_sel_t;

  typedef struct packed {
    logic     load;
    idx_sel_t idx_sel;
    logic     re;
    adr_sel_t raddr_sel;
    logic     we;
    adr_sel_t waddr_sel;
    logic     wdata_val;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     res_set;
    status_t  res_status;
    logic     res_found;
    logic     res_read;
    logic     out_load;
  } pal_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic ins_pos_ok;
    logic pos_ok;
    logic ins_more;
    logic idx_below_count;
    logic match;
  } pal_stat_t;

endpackage

@@ src/pal_ram.sv @@
`timescale 1ns / 1ps
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/pal_datapath.sv @@
`timescale 1ns / 1ps
`include "positional_array_list_macros.svh"
module pal_datapath
  import pal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  pal_cmd_t                cmd,
  output pal_stat_t               stat,
  input  logic [1:0]              in_operation,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [POS_W-1:0]        out_found_position,
  output logic [CNT_W-1:0]        out_list_length
);

  op_t              op_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  status_t          res_status_r;
  logic [VAL_W-1:0] res_value_r;
  logic [POS_W-1:0] res_found_r;

  status_t          out_status_r;
  logic [VAL_W-1:0] out_value_r;
  logic [POS_W-1:0] out_found_r;
  logic [CNT_W-1:0] out_length_r;

  logic [CNT_W-1:0]  idx_m1, pos_m1;
  logic [CNT_W-1:0]  raddr_full, waddr_full;
  logic [VAL_W-1:0]  wdata, rdata;

  assign idx_m1 = idx_r - CNT_W'(1);
  assign pos_m1 = CNT_W'(pos_r) - CNT_W'(1);

  always_comb begin
    case (cmd.raddr_sel)
      ADR_IDX:    raddr_full = idx_r;
      ADR_IDX_M1: raddr_full = idx_m1;
      ADR_POS_M1: raddr_full = pos_m1;
      default:    raddr_full = idx_r;
    endcase
    case (cmd.waddr_sel)
      ADR_IDX:    waddr_full = idx_r;
      ADR_IDX_M1: waddr_full = idx_m1;
      ADR_POS_M1: waddr_full = pos_m1;
      default:    waddr_full = idx_r;
    endcase
  end

  assign wdata = cmd.wdata_val ? val_r : rdata;

  pal_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr_full[ADDR_W-1:0]),
    .wdata (wdata),
    .re    (cmd.re),
    .raddr (raddr_full[ADDR_W-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.idx_sel)
      IDX_HOLD:  idx_nxt = idx_r;
      IDX_COUNT: idx_nxt = count_r;
      IDX_POS:   idx_nxt = CNT_W'(pos_r);
      IDX_ZERO:  idx_nxt = '0;
      IDX_INC:   idx_nxt = idx_r + CNT_W'(1);
      IDX_DEC:   idx_nxt = idx_m1;
      default:   idx_nxt = idx_r;
    endcase
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    stat.op              = op_r;
    stat.full            = ({1'b0, count_r} >= (CNT_W + 1)'(CAPACITY));
    stat.ins_pos_ok      = (pos_r != '0) &&
                           ({1'b0, pos_r} <= ({1'b0, count_r} + (CNT_W + 1)'(1)));
    stat.pos_ok          = (pos_r != '0) && (CNT_W'(pos_r) <= count_r);
    stat.ins_more        = (idx_r >= CNT_W'(pos_r));
    stat.idx_below_count = (idx_r < count_r);
    stat.match           = (rdata == val_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) begin
      op_r         <= op_t'(in_operation);
      val_r        <= in_value;
      pos_r        <= in_position;
      res_status_r <= ST_OK;
      res_value_r  <= '0;
      res_found_r  <= '0;
    end else begin
      if (cmd.res_set) begin
        res_status_r <= cmd.res_status;
      end
      if (cmd.res_found) begin
        res_found_r <= POS_W'(idx_r + CNT_W'(1));
      end
      if (cmd.res_read) begin
        res_value_r <= rdata;
      end
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_found_r  <= res_found_r;
      out_length_r <= count_r;
    end
  end

  assign out_status         = out_status_r;
  assign out_read_value     = out_value_r;
  assign out_found_position = out_found_r;
  assign out_list_length    = out_length_r;

  `PAL_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(CAPACITY))
  `PAL_ASSERT(a_write_in_list, clk, rst_n, !cmd.we || (waddr_full <= count_r))
  `PAL_ASSERT(a_read_in_list, clk, rst_n, !cmd.re || (raddr_full < count_r))
  `PAL_ASSERT(a_count_step, clk, rst_n,
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)) ||
    (count_r == $past(count_r) - CNT_W'(1)))

endmodule

@@ src/pal_ctrl.sv @@
`timescale 1ns / 1ps
`include "positional_array_list_macros.svh"
module pal_ctrl
  import pal_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pal_stat_t stat,
  output pal_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_TEST,
    S_INS_RD,
    S_INS_WR,
    S_PLACE,
    S_DEL_TEST,
    S_DEL_RD,
    S_DEL_WR,
    S_SCAN_TEST,
    S_SCAN_RD,
    S_SCAN_CK,
    S_GET_RD,
    S_GET_CK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_OVERFLOW;
              state_nxt      = S_DONE;
            end else if (!stat.ins_pos_ok) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_BAD_POSITION;
              state_nxt      = S_DONE;
            end else begin
              cmd.idx_sel = IDX_COUNT;
              state_nxt   = S_INS_TEST;
            end
          end
          OP_DELETE: begin
            if (!stat.pos_ok) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_BAD_POSITION;
              state_nxt      = S_DONE;
            end else begin
              cmd.idx_sel = IDX_POS;
              state_nxt   = S_DEL_TEST;
            end
          end
          OP_LOCATE: begin
            cmd.idx_sel = IDX_ZERO;
            state_nxt   = S_SCAN_TEST;
          end
          default: begin
            if (!stat.pos_ok) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = ST_BAD_POSITION;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_GET_RD;
            end
          end
        endcase
      end
      S_INS_TEST: begin
        state_nxt = stat.ins_more ? S_INS_RD : S_PLACE;
      end
      S_INS_RD: begin
        cmd.re        = 1'b1;
        cmd.raddr_sel = ADR_IDX_M1;
        state_nxt     = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.we        = 1'b1;
        cmd.waddr_sel = ADR_IDX;
        cmd.idx_sel   = IDX_DEC;
        state_nxt     = S_INS_TEST;
      end
      S_PLACE: begin
        cmd.we        = 1'b1;
        cmd.waddr_sel = ADR_POS_M1;
        cmd.wdata_val = 1'b1;
        cmd.cnt_inc   = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DEL_TEST: begin
        if (stat.idx_below_count) begin
          state_nxt = S_DEL_RD;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DEL_RD: begin
        cmd.re        = 1'b1;
        cmd.raddr_sel = ADR_IDX;
        state_nxt     = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd.we        = 1'b1;
        cmd.waddr_sel = ADR_IDX_M1;
        cmd.idx_sel   = IDX_INC;
        state_nxt     = S_DEL_TEST;
      end
      S_SCAN_TEST: begin
        if (stat.idx_below_count) begin
          state_nxt = S_SCAN_RD;
        end else begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end
      end
      S_SCAN_RD: begin
        cmd.re        = 1'b1;
        cmd.raddr_sel = ADR_IDX;
        state_nxt     = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (stat.match) begin
          cmd.res_found = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.idx_sel = IDX_INC;
          state_nxt   = S_SCAN_TEST;
        end
      end
      S_GET_RD: begin
        cmd.re        = 1'b1;
        cmd.raddr_sel = ADR_POS_M1;
        state_nxt     = S_GET_CK;
      end
      S_GET_CK: begin
        cmd.res_read = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `PAL_ASSERT_NEXT(a_done_shows_beat, clk, rst_n,
    (state_r == S_DONE) && (!out_valid_r || out_ready),
    out_valid_r && (state_r == S_IDLE))
  `PAL_ASSERT(a_single_ram_op, clk, rst_n, !(cmd.we && cmd.re))

endmodule

@@ src/positional_array_list.sv @@
`timescale 1ns / 1ps
// From accepted beat to result beat, k = entries moved or compared: rejected items skip to the
//   result; get reads one entry; insert moves k = count - position + 1 entries up,
//   delete moves k = count - position entries down, locate compares entries up to a hit at index j
//   or all count entries on a miss; each entry costs a RAM read, then a write or compare.
// Throughput: one item at a time; the next beat is taken the cycle after the result is staged.
// Reset empties the list; entry storage is not cleared.
module positional_array_list
  import pal_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [POS_W-1:0]        out_found_position,
  output logic [CNT_W-1:0]        out_list_length
);

  pal_cmd_t  cmd;
  pal_stat_t stat;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pal_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

endmodule

@@ dv/positional_array_list_tb.sv @@
`timescale 1ns / 1ps
module positional_array_list_tb;
  import pal_pkg::*;

  localparam int RANDOM_ITEMS = 1826;
  localparam int DIRECTED_ROWS = 24;
  localparam int TAIL_CYCLES = 400;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        found_position;
    logic [CNT_W-1:0]        list_length;
  } list_result_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic                    typed;
    list_result_t            want;
  } directed_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_operation = OP_GET;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_read_value;
  logic [POS_W-1:0]        out_found_position;
  logic [CNT_W-1:0]        out_list_length;

  logic signed [VAL_W-1:0] list_words [CAPACITY];
  int                      list_len;
  list_result_t            pending_results [$];
  list_result_t            oldest;
  directed_row_t           directed [DIRECTED_ROWS];
  int                      errors = 0;
  int                      cycle_count = 0;
  logic                    calm = 1'b0;

  positional_array_list dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic list_result_t list_apply(op_t op, logic signed [VAL_W-1:0] v,
                                              logic [POS_W-1:0] p);
    list_result_t r;
    int           pos;
    r = '{ST_OK, '0, '0, '0};
    pos = p;
    case (op)
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_OVERFLOW;
        end else if (pos < 1 || pos > list_len + 1) begin
          r.status = ST_BAD_POSITION;
        end else begin
          for (int j = list_len; j >= pos; j--) list_words[j] = list_words[j-1];
          list_words[pos-1] = v;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > list_len) begin
          r.status = ST_BAD_POSITION;
        end else begin
          for (int j = pos; j < list_len; j++) list_words[j-1] = list_words[j];
          list_len--;
        end
      end
      OP_LOCATE: begin
        r.status = ST_NOT_FOUND;
        for (int j = 0; j < list_len; j++) begin
          if (r.status == ST_NOT_FOUND && list_words[j] == v) begin
            r.status = ST_OK;
            r.found_position = POS_W'(j + 1);
          end
        end
      end
      default: begin
        if (pos < 1 || pos > list_len) begin
          r.status = ST_BAD_POSITION;
        end else begin
          r.read_value = list_words[pos-1];
        end
      end
    endcase
    r.list_length = CNT_W'(list_len);
    return r;
  endfunction

  // hold valid high across back-to-back beats; drop it only for a gap
  task automatic send_beat(op_t op, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p,
                           logic typed, list_result_t want);
    list_result_t predicted;
    int           gap;
    if (!calm && $urandom_range(0, 99) < 13) begin
      gap = 1;
      while ($urandom_range(0, 99) < 30) gap++;
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    in_position  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = list_apply(op, v, p);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_word();
    logic signed [VAL_W-1:0] w;
    case ($urandom_range(0, 9))
      0: w = 32'sh80000000;
      1: w = 32'sh7FFFFFFF;
      2, 3, 4, 5: begin
        w = $urandom_range(0, 8);
        w = w - 4;
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic logic [POS_W-1:0] pick_position(op_t op);
    int hi;
    hi = (op == OP_INSERT) ? list_len + 1 : list_len;
    if (hi < 1 || $urandom_range(0, 99) < 10) return POS_W'($urandom_range(0, 255));
    if (op == OP_INSERT && list_len >= CAPACITY && $urandom_range(0, 1) == 1)
      return POS_W'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0: return POS_W'(1);
      1: return POS_W'(hi);
      default: return POS_W'($urandom_range(1, hi));
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: status %0d len %0d",
               out_status, out_list_length);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_status);
          errors++;
        end
        if (out_read_value !== oldest.read_value) begin
          $error("read_value: expected %0d, got %0d", oldest.read_value, out_read_value);
          errors++;
        end
        if (out_found_position !== oldest.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 oldest.found_position, out_found_position);
          errors++;
        end
        if (out_list_length !== oldest.list_length) begin
          $error("list_length: expected %0d, got %0d", oldest.list_length, out_list_length);
          errors++;
        end
      end
    end
    out_ready <= calm || ($urandom_range(0, 99) >= 13);
  end

  initial begin
    op_t                     op;
    logic signed [VAL_W-1:0] v;
    int                      target;
    int                      dwell;
    int                      r;
    directed = '{
      '{OP_GET,    32'sd0,          8'd0,   1'b1, '{ST_BAD_POSITION, 32'sd0, 8'd0, 8'd0}},
      '{OP_DELETE, 32'sd0,          8'd0,   1'b1, '{ST_BAD_POSITION, 32'sd0, 8'd0, 8'd0}},
      '{OP_LOCATE, 32'sd0,          8'd0,   1'b1, '{ST_NOT_FOUND,    32'sd0, 8'd0, 8'd0}},
      '{OP_INSERT, 32'sd5,          8'd0,   1'b1, '{ST_BAD_POSITION, 32'sd0, 8'd0, 8'd0}},
      '{OP_INSERT, 32'sd5,          8'd2,   1'b1, '{ST_BAD_POSITION, 32'sd0, 8'd0, 8'd0}},
      '{OP_INSERT, 32'sh7FFFFFFF,   8'd1,   1'b1, '{ST_OK,           32'sd0, 8'd0, 8'd1}},
      '{OP_INSERT, 32'sh80000000,   8'd1,   1'b1, '{ST_OK,           32'sd0, 8'd0, 8'd2}},
      '{OP_INSERT, -32'sd1,         8'd3,   1'b1, '{ST_OK,           32'sd0, 8'd0, 8'd3}},
      '{OP_GET,    32'sd0,          8'd1,   1'b1, '{ST_OK, 32'sh80000000, 8'd0, 8'd3}},
      '{OP_GET,    32'sd0,          8'd3,   1'b1, '{ST_OK,           -32'sd1, 8'd0, 8'd3}},
      '{OP_GET,    32'sd0,          8'd4,   1'b1, '{ST_BAD_POSITION, 32'sd0, 8'd0, 8'd3}},
      '{OP_GET,    32'sd0,          8'd255, 1'b1, '{ST_BAD_POSITION, 32'sd0, 8'd0, 8'd3}},
      '{OP_LOCATE, 32'sh7FFFFFFF,   8'd0,   1'b0, '0},
      '{OP_LOCATE, 32'sd0,          8'd0,   1'b1, '{ST_NOT_FOUND,    32'sd0, 8'd0, 8'd3}},
      '{OP_INSERT, -32'sd1,         8'd2,   1'b0, '0},
      '{OP_LOCATE, -32'sd1,         8'd0,   1'b0, '0},
      '{OP_DELETE, 32'sd0,          8'd5,   1'b1, '{ST_BAD_POSITION, 32'sd0, 8'd0, 8'd4}},
      '{OP_DELETE, 32'sd0,          8'd2,   1'b0, '0},
      '{OP_LOCATE, -32'sd1,         8'd0,   1'b0, '0},
      '{OP_DELETE, 32'sd0,          8'd3,   1'b0, '0},
      '{OP_DELETE, 32'sd0,          8'd1,   1'b0, '0},
      '{OP_GET,    32'sd0,          8'd1,   1'b1, '{ST_OK, 32'sh7FFFFFFF, 8'd0, 8'd1}},
      '{OP_INSERT, 32'sh55AA55AA,   8'd255, 1'b1, '{ST_BAD_POSITION, 32'sd0, 8'd0, 8'd1}},
      '{OP_LOCATE, 32'sh80000000,   8'd0,   1'b1, '{ST_NOT_FOUND,    32'sd0, 8'd0, 8'd1}}
    };
    list_len = 0;
    foreach (list_words[i]) list_words[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_beat(directed[i].op, directed[i].value, directed[i].position,
                directed[i].typed, directed[i].want);
    drain_results();

    target = 0;
    dwell = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 700 && n < 1000);
      if (n == 1200) drain_results();
      if (list_len == target) begin
        if (dwell > 0) begin
          dwell--;
        end else begin
          r = $urandom_range(0, 99);
          target = (r < 20) ? CAPACITY : (r < 35) ? 0 : $urandom_range(1, 40);
          dwell = $urandom_range(0, 6);
        end
      end
      r = $urandom_range(0, 99);
      if (list_len == target)
        op = (r < 30) ? OP_INSERT : (r < 50) ? OP_DELETE : (r < 75) ? OP_LOCATE : OP_GET;
      else if (target > list_len)
        op = (r < 55) ? OP_INSERT : (r < 70) ? OP_DELETE : (r < 85) ? OP_LOCATE : OP_GET;
      else
        op = (r < 15) ? OP_INSERT : (r < 60) ? OP_DELETE : (r < 80) ? OP_LOCATE : OP_GET;
      if (op == OP_LOCATE && list_len > 0 && $urandom_range(0, 99) < 60)
        v = list_words[$urandom_range(0, list_len - 1)];
      else
        v = pick_word();
      send_beat(op, v, pick_position(op), 1'b0, '0);
    end
    calm = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/pal_pkg.sv
src/pal_ram.sv
src/pal_datapath.sv
src/pal_ctrl.sv
src/positional_array_list.sv
dv/positional_array_list_tb.sv
